FILE: sv/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, sizes and helpers of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ARENA_WORDS   = 8192;
  localparam int AW_BITS       = $clog2(ARENA_WORDS);
  localparam int WORDS_BITS    = AW_BITS + 1;
  localparam int MAX_EXTENTS   = 64;
  localparam int IDX_BITS      = $clog2(MAX_EXTENTS);
  localparam int CNT_BITS      = IDX_BITS + 1;
  localparam int GRANULE_BYTES = 16;
  localparam int SUM_BITS      = WORDS_BITS + 2;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_REINIT = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_RANGE   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [AW_BITS-1:0]    start;
    logic [WORDS_BITS-1:0] words;
  } ext_entry_t;

  // Limits an extent so that it ends no later than the top of the arena.
  function automatic logic [WORDS_BITS-1:0] clip_top(input logic [AW_BITS-1:0] start,
                                                      input logic [SUM_BITS-1:0] words);
    logic [WORDS_BITS-1:0] room;
    room = WORDS_BITS'(ARENA_WORDS) - {1'b0, start};
    if (words > SUM_BITS'(room)) begin
      return room;
    end
    return words[WORDS_BITS-1:0];
  endfunction

endpackage

FILE: sv/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/first_fit_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_top
// First-fit allocator over an arena of 8-byte words with coalescing free.
// ----------------------------------------------------------------------------
// The block handles one item at a time and holds in_stall high from the
// cycle after acceptance until its result has been taken. All extent table
// traffic goes through one table RAM with registered read, so every table
// step is a read state followed by a check or write state. An allocate
// scans the extents in order until one fits, and reports no fit when the
// scan reaches the end of the table; removing a used-up extent moves every
// later entry down. A free reads the header word, then scans until a later
// extent or the end of the table; inserting an extent or merging two moves
// the entries that follow. An out-of-range free, a reinit and an unused
// mode go straight to the result state.
// After reset the block writes the initial extent in S_INIT before
// it takes its first item.
module first_fit_free_list_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_request_bytes,
  input  logic [15:0] in_free_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_block_offset,
  output logic [1:0]  out_status
);

  localparam int AWB = ffa_pkg::AW_BITS;
  localparam int WB  = ffa_pkg::WORDS_BITS;
  localparam int IB  = ffa_pkg::IDX_BITS;
  localparam int CB  = ffa_pkg::CNT_BITS;
  localparam int SB  = ffa_pkg::SUM_BITS;

  typedef enum logic [11:0] {
    S_INIT = 12'b0000_0000_0001,
    S_IDLE = 12'b0000_0000_0010,
    S_ARD  = 12'b0000_0000_0100,
    S_ACHK = 12'b0000_0000_1000,
    S_HRD  = 12'b0000_0001_0000,
    S_HCHK = 12'b0000_0010_0000,
    S_FRD  = 12'b0000_0100_0000,
    S_FCHK = 12'b0000_1000_0000,
    S_DEC  = 12'b0001_0000_0000,
    S_SRD  = 12'b0010_0000_0000,
    S_SWR  = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [WB-1:0]  arena_r;
  logic [CB-1:0]  cnt_r, cnt_nxt;
  logic [CB-1:0]  k_r, k_nxt;
  logic [CB-1:0]  lim_r, lim_nxt;
  logic           up_r, up_nxt;
  logic           pend_r, pend_nxt;
  logic           prev_vld_r, prev_vld_nxt;
  logic           next_vld_r, next_vld_nxt;
  ffa_pkg::ext_entry_t prev_r, prev_nxt;
  ffa_pkg::ext_entry_t next_r, next_nxt;
  logic [WB-1:0]  grant_r, grant_nxt;
  logic [AWB-1:0] h_r, h_nxt;
  logic [WB-1:0]  size_r, size_nxt;
  logic [15:0]    block_r, block_nxt;
  ffa_pkg::status_t status_r, status_nxt;

  logic                ext_we;
  logic [IB-1:0]       ext_waddr, ext_raddr;
  ffa_pkg::ext_entry_t ext_wdata, ext_rdata;
  logic                hdr_we;
  logic [AWB-1:0]      hdr_waddr;
  logic [WB-1:0]       hdr_wdata, hdr_rdata;

  logic [WB-1:0]  eff_arena;
  logic [AWB-1:0] in_word;
  logic [AWB:0]   q_granules;
  logic [WB-1:0]  new_words, top_word;
  logic [AWB-1:0] ret_word;
  logic [WB:0]    size_raw;
  logic [WB-1:0]  room;
  logic           mprev, mnext;
  logic [SB-1:0]  merge_sum;
  logic [AWB-1:0] merge_start;
  logic [CB-1:0]  src_idx;

  ffa_ram #(.WIDTH($bits(ffa_pkg::ext_entry_t)), .DEPTH(ffa_pkg::MAX_EXTENTS)) u_ext_ram (
    .clk   (clk),
    .we    (ext_we),
    .waddr (ext_waddr),
    .wdata (ext_wdata),
    .raddr (ext_raddr),
    .rdata (ext_rdata)
  );

  ffa_ram #(.WIDTH(WB), .DEPTH(ffa_pkg::ARENA_WORDS)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hdr_waddr),
    .wdata (hdr_wdata),
    .raddr (h_r),
    .rdata (hdr_rdata)
  );

  always_comb begin
    eff_arena = arena_r;
    if (arena_r < WB'(2)) begin
      eff_arena = WB'(2);
    end else if (arena_r > WB'(ffa_pkg::ARENA_WORDS)) begin
      eff_arena = WB'(ffa_pkg::ARENA_WORDS);
    end
  end

  assign in_word    = in_free_offset[15:3];
  assign q_granules = {2'b00, in_request_bytes[15:4]} + (AWB+1)'(1);
  assign top_word   = {1'b0, ext_rdata.start} + ext_rdata.words;
  assign new_words  = ext_rdata.words - grant_r - WB'(1);
  assign ret_word   = AWB'(top_word - grant_r);
  assign size_raw   = {1'b0, hdr_rdata} + (WB+1)'(1);
  assign room       = eff_arena - {1'b0, h_r};
  assign src_idx    = up_r ? k_r + CB'(1) : k_r - CB'(1);

  assign mprev = prev_vld_r && (({1'b0, prev_r.start} + prev_r.words) == {1'b0, h_r});
  assign mnext = next_vld_r && (({1'b0, h_r} + size_r) == {1'b0, next_r.start});
  assign merge_start = mprev ? prev_r.start : h_r;
  assign merge_sum = SB'(mprev ? prev_r.words : '0) + SB'(size_r)
                   + SB'(mnext ? next_r.words : '0);

  assign ext_raddr = (state_r == S_SRD) ? src_idx[IB-1:0] : k_r[IB-1:0];

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    lim_nxt      = lim_r;
    up_nxt       = up_r;
    pend_nxt     = pend_r;
    prev_vld_nxt = prev_vld_r;
    next_vld_nxt = next_vld_r;
    prev_nxt     = prev_r;
    next_nxt     = next_r;
    grant_nxt    = grant_r;
    h_nxt        = h_r;
    size_nxt     = size_r;
    block_nxt    = block_r;
    status_nxt   = status_r;
    ext_we       = 1'b0;
    ext_waddr    = k_r[IB-1:0];
    ext_wdata    = ext_rdata;
    hdr_we       = 1'b0;
    hdr_waddr    = ret_word - AWB'(1);
    hdr_wdata    = grant_r;

    unique case (state_r)
      S_INIT: begin
        ext_we    = 1'b1;
        ext_waddr = '0;
        ext_wdata = '{start: '0, words: eff_arena};
        cnt_nxt   = CB'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        block_nxt  = '0;
        status_nxt = ffa_pkg::ST_OK;
        k_nxt      = '0;
        if (in_valid) begin
          unique case (ffa_pkg::mode_t'(in_mode))
            ffa_pkg::MODE_ALLOC: begin
              grant_nxt = {q_granules[AWB-1:0], 1'b0};
              state_nxt = S_ARD;
            end
            ffa_pkg::MODE_FREE: begin
              h_nxt = in_word - AWB'(1);
              if (in_word == '0 || {1'b0, in_word} >= eff_arena) begin
                status_nxt = ffa_pkg::ST_RANGE;
                state_nxt  = S_OUT;
              end else begin
                state_nxt = S_HRD;
              end
            end
            ffa_pkg::MODE_REINIT: begin
              ext_we    = 1'b1;
              ext_waddr = '0;
              ext_wdata = '{start: '0, words: eff_arena};
              cnt_nxt   = CB'(1);
              state_nxt = S_OUT;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_ARD: begin
        if (k_r == cnt_r) begin
          status_nxt = ffa_pkg::ST_NO_FIT;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if ({1'b0, ext_rdata.words} >= {1'b0, grant_r} + (WB+1)'(1)) begin
          hdr_we    = 1'b1;
          block_nxt = {ret_word, 3'b000};
          if (new_words == '0) begin
            // The extent is used up: close the gap by moving later entries down.
            cnt_nxt   = cnt_r - CB'(1);
            up_nxt    = 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = S_SRD;
          end else begin
            ext_we    = 1'b1;
            ext_wdata = '{start: ext_rdata.start, words: new_words};
            state_nxt = S_OUT;
          end
        end else begin
          k_nxt     = k_r + CB'(1);
          state_nxt = S_ARD;
        end
      end
      S_HRD: begin
        state_nxt = S_HCHK;
      end
      S_HCHK: begin
        size_nxt     = (size_raw > {1'b0, room}) ? room : size_raw[WB-1:0];
        prev_vld_nxt = 1'b0;
        next_vld_nxt = 1'b0;
        state_nxt    = S_FRD;
      end
      S_FRD: begin
        state_nxt = (k_r == cnt_r) ? S_DEC : S_FCHK;
      end
      S_FCHK: begin
        if (ext_rdata.start <= h_r) begin
          prev_nxt     = ext_rdata;
          prev_vld_nxt = 1'b1;
          k_nxt        = k_r + CB'(1);
          state_nxt    = S_FRD;
        end else begin
          next_nxt     = ext_rdata;
          next_vld_nxt = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        // k_r is the first entry that starts above the freed header word, or cnt_r if none does.
        if (mprev || mnext) begin
          ext_we    = 1'b1;
          ext_waddr = mprev ? IB'(k_r - CB'(1)) : k_r[IB-1:0];
          ext_wdata = '{start: merge_start, words: ffa_pkg::clip_top(merge_start, merge_sum)};
          if (mprev && mnext) begin
            cnt_nxt   = cnt_r - CB'(1);
            up_nxt    = 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = S_SRD;
          end else begin
            state_nxt = S_OUT;
          end
        end else if (cnt_r >= CB'(ffa_pkg::MAX_EXTENTS)) begin
          status_nxt = ffa_pkg::ST_FULL;
          state_nxt  = S_OUT;
        end else begin
          lim_nxt   = k_r;
          k_nxt     = cnt_r;
          cnt_nxt   = cnt_r + CB'(1);
          up_nxt    = 1'b0;
          pend_nxt  = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if ((up_r && k_r < cnt_r) || (!up_r && k_r > lim_r)) begin
          state_nxt = S_SWR;
        end else begin
          if (pend_r) begin
            ext_we    = 1'b1;
            ext_waddr = lim_r[IB-1:0];
            ext_wdata = '{start: h_r, words: size_r};
          end
          state_nxt = S_OUT;
        end
      end
      S_SWR: begin
        ext_we    = 1'b1;
        ext_waddr = k_r[IB-1:0];
        ext_wdata = ext_rdata;
        k_nxt     = src_idx;
        state_nxt = S_SRD;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      arena_r <= WB'(ffa_pkg::ARENA_WORDS);
      cnt_r   <= CB'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        arena_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    lim_r      <= lim_nxt;
    up_r       <= up_nxt;
    pend_r     <= pend_nxt;
    prev_vld_r <= prev_vld_nxt;
    next_vld_r <= next_vld_nxt;
    prev_r     <= prev_nxt;
    next_r     <= next_nxt;
    grant_r    <= grant_nxt;
    h_r        <= h_nxt;
    size_r     <= size_nxt;
    block_r    <= block_nxt;
    status_r   <= status_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_block_offset = block_r;
  assign out_status       = status_r;

endmodule

FILE: sv/ffa_chk.sv
// ----------------------------------------------------------------------------
// ffa_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_block_offset,
  input logic [1:0]  out_status
);

  // A result that waits keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_block_offset) && $stable(out_status))
    else $error("result changed while stalled");

  // Only a successful allocate returns a nonzero offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffa_pkg::ST_OK |-> out_block_offset == 16'd0)
    else $error("failed item carries an offset");

  // Only one item is in flight: an accepted item closes the input.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after acceptance");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result waits");

  // Granted offsets are word aligned.
  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_block_offset[2:0] == 3'd0)
    else $error("offset not word aligned");

endmodule

bind first_fit_free_list_allocator_top ffa_chk u_ffa_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_block_offset (out_block_offset),
  .out_status       (out_status)
);
